FILE: src/rbt_pkg.sv
// rigid body torque package: payload structs, config indexes, fixed-point helpers
// used by all rtl files of the rigid_body_torque block
package rbt_pkg;

   typedef struct packed {
      logic signed [31:0] moment_z;
      logic signed [31:0] moment_y;
      logic signed [31:0] moment_x;
      logic signed [31:0] omega_z;
      logic signed [31:0] omega_y;
      logic signed [31:0] omega_x;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] torque_z;
      logic signed [31:0] torque_y;
      logic signed [31:0] torque_x;
   } rsp_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INERTIA_X = 3'd0,
      CSR_INERTIA_Y = 3'd1,
      CSR_INERTIA_Z = 3'd2,
      CSR_MOMENT_EN = 3'd3,
      CSR_GYRO_EN   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [47:0] row_z;
      logic [47:0] row_y;
      logic [47:0] row_x;
      logic        moment_en;
      logic        gyro_en;
   } cfg_type;

   // round half up then floor, 8 bits dropped
   function automatic logic signed [26:0] rnd8_36(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = v + 36'sd128;
      return t[34:8];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7fffffff) return 32'sh7fffffff;
      else if (v < -64'sh80000000) return -32'sh80000000;
      else return v[31:0];
   endfunction

endpackage

FILE: src/rbt_matrix.sv
// rotation matrix stages: quaternion products, then entries rounded to q.20
// depends on rbt_pkg
module rbt_matrix
   import rbt_pkg::*;
(
   input  logic                clock,
   input  logic signed [15:0]  qw,
   input  logic signed [15:0]  qx,
   input  logic signed [15:0]  qy,
   input  logic signed [15:0]  qz,
   output logic signed [26:0]  m_ff [9]
);
   logic signed [31:0] p_ff [10];
   logic signed [26:0] m_in [9];
   logic signed [35:0] e [9];

   always_ff @(posedge clock) begin
      p_ff[0] <= qw * qw;
      p_ff[1] <= qx * qx;
      p_ff[2] <= qy * qy;
      p_ff[3] <= qz * qz;
      p_ff[4] <= qx * qy;
      p_ff[5] <= qx * qz;
      p_ff[6] <= qy * qz;
      p_ff[7] <= qw * qx;
      p_ff[8] <= qw * qy;
      p_ff[9] <= qw * qz;
   end

   always_comb begin
      e[0] = 36'(p_ff[0]) + 36'(p_ff[1]) - 36'(p_ff[2]) - 36'(p_ff[3]);
      e[1] = (36'(p_ff[4]) - 36'(p_ff[9])) <<< 1;
      e[2] = (36'(p_ff[5]) + 36'(p_ff[8])) <<< 1;
      e[3] = (36'(p_ff[4]) + 36'(p_ff[9])) <<< 1;
      e[4] = 36'(p_ff[0]) - 36'(p_ff[1]) + 36'(p_ff[2]) - 36'(p_ff[3]);
      e[5] = (36'(p_ff[6]) - 36'(p_ff[7])) <<< 1;
      e[6] = (36'(p_ff[5]) - 36'(p_ff[8])) <<< 1;
      e[7] = (36'(p_ff[6]) + 36'(p_ff[7])) <<< 1;
      e[8] = 36'(p_ff[0]) - 36'(p_ff[1]) - 36'(p_ff[2]) + 36'(p_ff[3]);
      for (int k = 0; k < 9; k++) m_in[k] = rnd8_36(e[k]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) m_ff[k] <= m_in[k];
   end
endmodule

FILE: src/rbt_gyro.sv
// gyroscopic term stages: inertia times omega, with omega delayed alongside for the cross product
// depends on rbt_pkg
module rbt_gyro
   import rbt_pkg::*;
(
   input  logic                clock,
   input  cfg_type             cfg,
   input  logic signed [31:0]  om [3],
   output logic signed [31:0]  iw_ff [3],
   output logic signed [31:0]  om_ff [3]
);
   logic signed [47:0] ip_ff [9];
   logic signed [31:0] omd_ff [3];
   logic [47:0]        row [3];
   logic signed [63:0] s [3];

   assign row[0] = cfg.row_x;
   assign row[1] = cfg.row_y;
   assign row[2] = cfg.row_z;

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ip_ff[3*r+c] <= $signed(row[r][16*c +: 16]) * om[c];
         end
         omd_ff[r] <= om[r];
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s[r] = 64'(ip_ff[3*r]) + 64'(ip_ff[3*r+1]) + 64'(ip_ff[3*r+2]) + 64'sd128;
         s[r] = s[r] >>> 8;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         iw_ff[r] <= sat32(s[r]);
         om_ff[r] <= omd_ff[r];
      end
   end
endmodule

FILE: src/rbt_combine.sv
// final stages: moment times matrix and cross products, rounding and saturation
// depends on rbt_pkg
module rbt_combine
   import rbt_pkg::*;
(
   input  logic                clock,
   input  cfg_type             cfg,
   input  logic signed [26:0]  m [9],
   input  logic signed [31:0]  mo [3],
   input  logic signed [31:0]  iw [3],
   input  logic signed [31:0]  om [3],
   output rsp_type             rsp_ff
);
   logic signed [58:0] mp_ff [9];
   logic signed [63:0] cp_ff [6];
   logic signed [63:0] aux, gy, t;
   logic signed [63:0] tq [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) mp_ff[3*j+i] <= mo[i] * m[3*i+j];
      end
      cp_ff[0] <= om[1] * iw[2];
      cp_ff[1] <= om[2] * iw[1];
      cp_ff[2] <= om[2] * iw[0];
      cp_ff[3] <= om[0] * iw[2];
      cp_ff[4] <= om[0] * iw[1];
      cp_ff[5] <= om[1] * iw[0];
   end

   always_comb begin
      aux = '0;
      gy  = '0;
      t   = '0;
      for (int j = 0; j < 3; j++) begin
         aux = 64'(mp_ff[3*j]) + 64'(mp_ff[3*j+1]) + 64'(mp_ff[3*j+2]) + 64'sd524288;
         aux = aux >>> 20;
         gy  = cp_ff[2*j] - cp_ff[2*j+1] + 64'sd32768;
         gy  = gy >>> 16;
         t   = (cfg.moment_en ? aux : 64'sd0) - (cfg.gyro_en ? gy : 64'sd0);
         tq[j] = t;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.torque_x <= sat32(tq[0]);
      rsp_ff.torque_y <= sat32(tq[1]);
      rsp_ff.torque_z <= sat32(tq[2]);
   end
endmodule

FILE: src/rigid_body_torque.sv
// rigid_body_torque top level: config registers, valid pipeline, stage modules
// depends on rbt_pkg, rbt_matrix, rbt_gyro, rbt_combine
// One torque result per accepted item, on rsp_valid for one cycle once start has passed
// the vld_ff chain. busy is never high: a new item may start every cycle, set by the fully
// pipelined multiplier stages (products, sums, final products, final sums). The receiver
// cannot stall. Config writes are always ready and take effect at once; write only while
// no item is in flight.
module rigid_body_torque
   import rbt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);
   cfg_type            cfg_ff;
   logic [3:0]         vld_ff;
   logic signed [31:0] om [3];
   logic signed [31:0] mo_ff [2][3];
   logic signed [26:0] m [9];
   logic signed [31:0] iw [3];
   logic signed [31:0] omg [3];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INERTIA_X: cfg_ff.row_x     <= csr_data;
               CSR_INERTIA_Y: cfg_ff.row_y     <= csr_data;
               CSR_INERTIA_Z: cfg_ff.row_z     <= csr_data;
               CSR_MOMENT_EN: cfg_ff.moment_en <= csr_data[0];
               CSR_GYRO_EN:   cfg_ff.gyro_en   <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   assign om[0] = req_data.omega_x;
   assign om[1] = req_data.omega_y;
   assign om[2] = req_data.omega_z;

   always_ff @(posedge clock) begin
      mo_ff[0][0] <= req_data.moment_x;
      mo_ff[0][1] <= req_data.moment_y;
      mo_ff[0][2] <= req_data.moment_z;
      mo_ff[1]    <= mo_ff[0];
   end

   rbt_matrix u_matrix (
      .clock (clock),
      .qw    (req_data.quat_w),
      .qx    (req_data.quat_x),
      .qy    (req_data.quat_y),
      .qz    (req_data.quat_z),
      .m_ff  (m)
   );

   rbt_gyro u_gyro (
      .clock (clock),
      .cfg   (cfg_ff),
      .om    (om),
      .iw_ff (iw),
      .om_ff (omg)
   );

   rbt_combine u_combine (
      .clock  (clock),
      .cfg    (cfg_ff),
      .m      (m),
      .mo     (mo_ff[1]),
      .iw     (iw),
      .om     (omg),
      .rsp_ff (rsp_data)
   );

   assign rsp_valid = vld_ff[3];
endmodule
